[src/assert_macros.svh]
// assertion macros included by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bba_pkg.sv]
// types and constants of the bitmap block allocator
package bba_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int unsigned LEN_W   = 9;
  localparam int unsigned BLOCK_W = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned NUM_W   = 9;

  localparam logic [NUM_W-1:0] NUM_BLOCKS_RESET = 9'd256;
  localparam int unsigned      BLOCK_CAP        = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic shift;
    logic wr_bit;
  } map_ctrl_t;

endpackage

[src/bba_req_if.sv]
// request channel: command, run length and start block
interface bba_req_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [bba_pkg::LEN_W-1:0]         run_length;
  logic [bba_pkg::BLOCK_W-1:0]       start_block;

  modport source (output valid, command, run_length, start_block, input ready);
  modport sink   (input valid, command, run_length, start_block, output ready);
endinterface

[src/bba_rsp_if.sv]
// result channel: found flag, run start and used count
interface bba_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [bba_pkg::BLOCK_W-1:0]       alloc_start;
  logic [bba_pkg::COUNT_W-1:0]       used_count;

  modport source (output valid, found, alloc_start, used_count, input ready);
  modport sink   (input valid, found, alloc_start, used_count, output ready);
endinterface

[src/bba_map.sv]
// usage map kept as a rotating shift register, one block per cycle at the head while shifting
module bba_map #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bba_pkg::map_ctrl_t ctrl_i,
  output logic               head_o
);

  logic [MAX_BLOCKS-1:0] map_q, map_d;

  always_comb begin
    map_d = map_q;
    if (ctrl_i.shift) begin
      map_d = {ctrl_i.wr_bit, map_q[MAX_BLOCKS-1:1]};
    end
  end

  // block 0 starts used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MAX_BLOCKS'(1);
    end else begin
      map_q <= map_d;
    end
  end

  assign head_o = map_q[0];

endmodule

[src/bitmap_block_allocator.sv]
// bitmap block allocator: first-fit contiguous run allocation over a usage map
//
// req_i takes one transaction (command, run_length, start_block) when valid and
// ready are high; ready is high only while the block is idle. rsp_o returns
// exactly one transaction per request: found, alloc_start and used_count.
// cfg_we_i/cfg_wdata_i write num_blocks; the user must write it only while
// no request is in flight, as the block itself does not enforce this. The
// usage map rotates past a single head bit, one block per clock while the
// block scans or updates. An allocate takes one rotation to find the first
// fitting run and a second to mark it and recount; a free clears and
// recounts in one rotation, and the block then returns to idle.
// The result sits in an output register; a stalled receiver lets the next
// request be accepted and worked on, and that request waits at its end
// until the register is free.
// Reset marks block 0 used, clears all others and sets num_blocks to 256;
// there is no clearing pass.
module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bba_pkg::NUM_W-1:0]    cfg_wdata_i,
  bba_req_if.sink                      req_i,
  bba_rsp_if.source                    rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CW    = (IDX_W > 9 ? IDX_W : 9) + 2;
  localparam int unsigned CAP   = (MAX_BLOCKS < bba_pkg::BLOCK_CAP) ? MAX_BLOCKS
                                                                    : bba_pkg::BLOCK_CAP;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  bba_pkg::state_e state_q, state_d;

  logic [bba_pkg::NUM_W-1:0]   num_blocks_q;
  logic [bba_pkg::NUM_W-1:0]   n_act;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        cmd_q, cmd_d;
  logic [bba_pkg::LEN_W-1:0]   len_q, len_d;
  logic [bba_pkg::BLOCK_W-1:0] start_q, start_d;
  logic [bba_pkg::LEN_W-1:0]   run_q, run_d;
  logic                        found_q, found_d;
  logic [bba_pkg::BLOCK_W-1:0] first_q, first_d;
  logic [bba_pkg::COUNT_W-1:0] count_q, count_d;

  logic                        rsp_valid_q;
  logic                        rsp_found_q;
  logic [bba_pkg::BLOCK_W-1:0] rsp_start_q;
  logic [bba_pkg::COUNT_W-1:0] rsp_count_q;

  logic                        accept;
  logic                        last;
  logic                        slot_free;
  logic                        load_rsp;
  logic                        head;
  logic                        new_bit;
  logic                        in_active;
  logic                        in_alloc;
  logic                        in_free;
  logic                        scan_hit;
  bba_pkg::map_ctrl_t          map_ctrl;

  logic [CW-1:0] idx_x, n_x, len_x, first_x, start_x;

  bba_map #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (map_ctrl),
    .head_o (head)
  );

  assign n_act = (num_blocks_q > bba_pkg::NUM_W'(CAP)) ? bba_pkg::NUM_W'(CAP) : num_blocks_q;

  assign idx_x   = CW'(idx_q);
  assign n_x     = CW'(n_act);
  assign len_x   = CW'(len_q);
  assign first_x = CW'(first_q);
  assign start_x = CW'(start_q);

  assign last      = (idx_q == LAST_IDX);
  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign accept    = req_i.valid && req_i.ready;

  assign in_active = (idx_x < n_x);
  assign scan_hit  = !found_q && in_active && !head
                     && ((CW'(run_q) + CW'(1)) == len_x);
  assign in_alloc  = found_q && (idx_x >= first_x) && (idx_x < first_x + len_x);
  assign in_free   = (cmd_q == bba_pkg::CMD_FREE) && in_active
                     && (idx_x >= start_x) && (idx_x < start_x + len_x);
  assign new_bit   = in_alloc ? 1'b1 : (in_free ? 1'b0 : head);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.command == bba_pkg::CMD_ALLOC) ? bba_pkg::ST_SCAN
                                                          : bba_pkg::ST_UPDATE;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (last) begin
          state_d = bba_pkg::ST_UPDATE;
        end
      end
      bba_pkg::ST_UPDATE: begin
        if (last) begin
          state_d = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_DONE: begin
        if (slot_free) begin
          state_d = bba_pkg::ST_IDLE;
        end
      end
      default: state_d = bba_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready     = 1'b0;
    map_ctrl.shift  = 1'b0;
    map_ctrl.wr_bit = head;
    load_rsp        = 1'b0;
    case (state_q)
      bba_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      bba_pkg::ST_SCAN: begin
        map_ctrl.shift = 1'b1;
      end
      bba_pkg::ST_UPDATE: begin
        map_ctrl.shift  = 1'b1;
        map_ctrl.wr_bit = new_bit;
      end
      bba_pkg::ST_DONE: begin
        load_rsp = slot_free;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    start_d = start_q;
    run_d   = run_q;
    found_d = found_q;
    first_d = first_q;
    count_d = count_q;
    if (accept) begin
      cmd_d   = req_i.command;
      len_d   = req_i.run_length;
      start_d = req_i.start_block;
      idx_d   = '0;
      run_d   = '0;
      found_d = 1'b0;
      first_d = '0;
      count_d = '0;
    end else if (state_q == bba_pkg::ST_SCAN) begin
      idx_d = last ? '0 : idx_q + IDX_W'(1);
      // run length only grows inside the active range, so it stays within 9 bits
      if (in_active) begin
        run_d = head ? '0 : run_q + bba_pkg::LEN_W'(1);
      end
      if (scan_hit) begin
        found_d = 1'b1;
        first_d = bba_pkg::BLOCK_W'(idx_x + CW'(1) - len_x);
      end
    end else if (state_q == bba_pkg::ST_UPDATE) begin
      idx_d = last ? '0 : idx_q + IDX_W'(1);
      if (in_active && new_bit) begin
        count_d = count_q + bba_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bba_pkg::ST_IDLE;
      num_blocks_q <= bba_pkg::NUM_BLOCKS_RESET;
      idx_q        <= '0;
      found_q      <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        num_blocks_q <= cfg_wdata_i;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    len_q   <= len_d;
    start_q <= start_d;
    run_q   <= run_d;
    first_q <= first_d;
    count_q <= count_d;
    if (load_rsp) begin
      rsp_found_q <= found_q;
      rsp_start_q <= found_q ? first_q : '0;
      rsp_count_q <= count_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.alloc_start = rsp_start_q;
  assign rsp_o.used_count  = rsp_count_q;

`include "assert_macros.svh"

  `BBA_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != bba_pkg::ST_IDLE,
                  "request accepted but block stayed idle")
  `BBA_ASSERT_IMP(a_found_only_alloc, found_q, cmd_q == bba_pkg::CMD_ALLOC,
                  "run found during a free")
  `BBA_ASSERT_IMP(a_idle_index_zero, state_q == bba_pkg::ST_IDLE, idx_q == '0,
                  "map not aligned to block 0 while idle")
  `BBA_ASSERT_NXT(a_load_sets_valid, load_rsp, rsp_valid_q,
                  "result load did not raise valid")

endmodule

[tb/testbench.sv]
// self-checking testbench for the bitmap block allocator: directed table, then random requests
`timescale 1ns / 100ps

module testbench;

  localparam int DIR_ROWS  = 29;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 104;
  localparam int LONG_HOLD = 3000;

  typedef struct packed {
    logic                        found;
    logic [bba_pkg::BLOCK_W-1:0] alloc_start;
    logic [bba_pkg::COUNT_W-1:0] used_count;
  } alloc_rsp_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_CALC,
    ROW_FIXED
  } row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [bba_pkg::NUM_W-1:0]   cfg_value;
    logic                        command;
    logic [bba_pkg::LEN_W-1:0]   run_length;
    logic [bba_pkg::BLOCK_W-1:0] start_block;
    alloc_rsp_t                  fixed;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [bba_pkg::NUM_W-1:0] cfg_wdata_i;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  bitmap_block_allocator #(
    .MAX_BLOCKS(256)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow of the usage map and the block count register
  logic [255:0]              usage_map;
  logic [bba_pkg::NUM_W-1:0] blocks_cfg;

  alloc_rsp_t alloc_results_q[$];
  int         mismatches    = 0;
  int         burst_left    = 0;
  int         hold_requests = 0;
  int         hold_served   = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b1, 8'd1,   9'd2}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd0,   8'hff,  '{1'b0, 8'd0,   9'd2}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd256, 8'd0,   '{1'b0, 8'd0,   9'd2}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd254, 8'd0,   '{1'b1, 8'd2,   9'd256}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b0, 8'd0,   9'd256}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd256, 8'd0,   '{1'b0, 8'd0,   9'd0}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd256, 8'd0,   '{1'b1, 8'd0,   9'd256}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd256, 8'd255, '{1'b0, 8'd0,   9'd255}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd1,   8'd255, '{1'b0, 8'd0,   9'd255}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b1, 8'd255, 9'd256}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd0,   8'd100, '{1'b0, 8'd0,   9'd256}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd511, 8'd0,   '{1'b0, 8'd0,   9'd0}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd511, 8'd0,   '{1'b0, 8'd0,   9'd0}},
    '{ROW_CALC,  9'd0,   bba_pkg::CMD_ALLOC, 9'd5,   8'd0,   '0},
    '{ROW_CALC,  9'd0,   bba_pkg::CMD_ALLOC, 9'd7,   8'hff,  '0},
    '{ROW_CALC,  9'd0,   bba_pkg::CMD_FREE,  9'd2,   8'd3,   '0},
    '{ROW_CALC,  9'd0,   bba_pkg::CMD_ALLOC, 9'd2,   8'd0,   '0},
    '{ROW_CALC,  9'd0,   bba_pkg::CMD_ALLOC, 9'd3,   8'h80,  '0},
    '{ROW_CFG,   9'd8,   bba_pkg::CMD_ALLOC, 9'd0,   8'd0,   '0},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b0, 8'd0,   9'd8}},
    '{ROW_CFG,   9'd16,  bba_pkg::CMD_ALLOC, 9'd0,   8'd0,   '0},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b1, 8'd15,  9'd16}},
    '{ROW_CFG,   9'd4,   bba_pkg::CMD_ALLOC, 9'd0,   8'd0,   '0},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd1,   8'd2,   '{1'b0, 8'd0,   9'd3}},
    '{ROW_CFG,   9'd0,   bba_pkg::CMD_ALLOC, 9'd0,   8'd0,   '0},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b0, 8'd0,   9'd0}},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_FREE,  9'd5,   8'd0,   '{1'b0, 8'd0,   9'd0}},
    '{ROW_CFG,   9'd511, bba_pkg::CMD_ALLOC, 9'd0,   8'd0,   '0},
    '{ROW_FIXED, 9'd0,   bba_pkg::CMD_ALLOC, 9'd1,   8'd0,   '{1'b1, 8'd2,   9'd16}}
  };

  logic [bba_pkg::NUM_W-1:0] phase_blocks [PHASES] = '{
    9'd256, 9'd37, 9'd1, 9'd511, 9'd128, 9'd9, 9'd200, 9'd256
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int active_blocks();
    return (blocks_cfg > 9'd256) ? 256 : int'(blocks_cfg);
  endfunction

  function automatic int used_blocks(input int n);
    int total;
    int i;
    total = 0;
    for (i = 0; i < n; i++) total += usage_map[i] ? 1 : 0;
    return total;
  endfunction

  // first-fit search / run clear on the shadow map, then recount below the active count
  function automatic alloc_rsp_t allocate_or_free(input logic cmd,
                                                   input logic [bba_pkg::LEN_W-1:0] len,
                                                   input logic [bba_pkg::BLOCK_W-1:0] start);
    alloc_rsp_t r;
    int n;
    int run;
    int first;
    int i;
    r = '0;
    n = active_blocks();
    run = 0;
    first = 0;
    if (cmd == bba_pkg::CMD_ALLOC) begin
      if (len != 0) begin
        for (i = 0; i < n && !r.found; i++) begin
          run = usage_map[i] ? 0 : run + 1;
          if (run == int'(len)) begin
            r.found = 1'b1;
            first = i + 1 - int'(len);
          end
        end
        if (r.found) begin
          for (i = first; i < first + int'(len); i++) usage_map[i] = 1'b1;
          r.alloc_start = first[bba_pkg::BLOCK_W-1:0];
        end
      end
    end else begin
      for (i = int'(start); i < int'(start) + int'(len) && i < n; i++) usage_map[i] = 1'b0;
    end
    r.used_count = bba_pkg::COUNT_W'(used_blocks(n));
    return r;
  endfunction

  // mostly well-sized requests, with zero, oversized and out-of-range ones mixed in
  task automatic pick_request(output logic cmd, output logic [bba_pkg::LEN_W-1:0] len,
                              output logic [bba_pkg::BLOCK_W-1:0] start);
    int n;
    int p;
    int alloc_pct;
    n = active_blocks();
    alloc_pct = (used_blocks(n) * 2 < n) ? 70 : 35;
    cmd = ($urandom_range(0, 99) < alloc_pct) ? bba_pkg::CMD_ALLOC : bba_pkg::CMD_FREE;
    start = bba_pkg::BLOCK_W'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (cmd == bba_pkg::CMD_ALLOC) begin
      if (p < 60) len = bba_pkg::LEN_W'($urandom_range(1, (n < 12) ? ((n < 1) ? 1 : n) : 12));
      else if (p < 85) len = bba_pkg::LEN_W'($urandom_range(1, (n < 1) ? 1 : n));
      else if (p < 90) len = 9'd0;
      else if (p < 95) len = bba_pkg::LEN_W'($urandom_range(257, 511));
      else len = (n < 256) ? bba_pkg::LEN_W'(n + 1) : 9'd256;
    end else begin
      if (p < 80 && n > 0) begin
        start = bba_pkg::BLOCK_W'($urandom_range(0, (n > 256) ? 255 : n - 1));
      end
      p = $urandom_range(0, 99);
      if (p < 70) len = bba_pkg::LEN_W'($urandom_range(1, 16));
      else if (p < 90) len = bba_pkg::LEN_W'($urandom_range(1, (n < 1) ? 1 : n));
      else if (p < 95) len = 9'd0;
      else len = bba_pkg::LEN_W'($urandom_range(0, 511));
    end
  endtask

  task automatic send_request(input logic cmd, input logic [bba_pkg::LEN_W-1:0] len,
                              input logic [bba_pkg::BLOCK_W-1:0] start, input logic use_fixed,
                              input alloc_rsp_t fixed);
    alloc_rsp_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.command     = cmd;
    req_if.run_length  = len;
    req_if.start_block = start;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
    end
    predicted = allocate_or_free(cmd, len, start);
    alloc_results_q.push_back(use_fixed ? fixed : predicted);
  endtask

  // sender goes quiet until every pending transaction has returned
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_block_count(input logic [bba_pkg::NUM_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    blocks_cfg  = value;
  endtask

  always @(posedge clk_i) begin : rsp_check
    alloc_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (alloc_results_q.size() == 0) begin
        $error("result transaction with no request pending");
        mismatches++;
      end else begin
        want = alloc_results_q.pop_front();
        if (rsp_if.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
          mismatches++;
        end
        if (rsp_if.alloc_start !== want.alloc_start) begin
          $error("alloc_start: expected %0d, actual %0d", want.alloc_start, rsp_if.alloc_start);
          mismatches++;
        end
        if (rsp_if.used_count !== want.used_count) begin
          $error("used_count: expected %0d, actual %0d", want.used_count, rsp_if.used_count);
          mismatches++;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin : rsp_stall_gen
    int mode;
    int left;
    int cyc;
    int k;
    mode = 0;
    left = 0;
    cyc  = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        rsp_if.ready = 1'b0;
        for (k = 1; k < LONG_HOLD; k++) @(negedge clk_i);
        hold_served++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 400);
        end
        left--;
        cyc++;
        case (mode)
          0: begin
            rsp_if.ready = 1'b1;
          end
          1: begin
            rsp_if.ready = 1'($urandom_range(0, 1));
          end
          2: begin
            rsp_if.ready = (cyc % 4) != 3;
          end
          default: begin
            rsp_if.ready = $urandom_range(0, 7) != 0;
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int row;
    int ph;
    int it;
    logic cmd;
    logic [bba_pkg::LEN_W-1:0] len;
    logic [bba_pkg::BLOCK_W-1:0] start;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.command     = bba_pkg::CMD_ALLOC;
    req_if.run_length  = '0;
    req_if.start_block = '0;
    usage_map  = 256'd1;
    blocks_cfg = bba_pkg::NUM_BLOCKS_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_rows[row].kind == ROW_CFG) begin
        drain_results();
        write_block_count(dir_rows[row].cfg_value);
      end else begin
        send_request(dir_rows[row].command, dir_rows[row].run_length, dir_rows[row].start_block,
                     dir_rows[row].kind == ROW_FIXED, dir_rows[row].fixed);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_block_count(phase_blocks[ph]);
      for (it = 0; it < PHASE_LEN; it++) begin
        // long receiver stall so the output register and the input both back up
        if (ph == 1 && it == 30) hold_requests++;
        if (ph == 4 && it == 50) drain_results();
        pick_request(cmd, len, start);
        send_request(cmd, len, start, 1'b0, '0);
      end
    end

    drain_results();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : run_limit
    #30ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/bba_pkg.sv
src/bba_req_if.sv
src/bba_rsp_if.sv
src/bba_map.sv
src/bitmap_block_allocator.sv
tb/testbench.sv
